/* hdl/i2c_master_transaction_sequencer_defines.svh */
// ----------------------------------------------------------------------------
// I2C master sequencer assertion macros
// Shared property wrappers; every use samples clk and is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define I2CS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define I2CS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/i2cs_pkg.sv */
// ----------------------------------------------------------------------------
// i2cs_pkg
// Types, codes and the microprogram of the I2C master transaction sequencer.
// ----------------------------------------------------------------------------
package i2cs_pkg;

	localparam int TX_DEPTH = 8;
	localparam int RX_DEPTH = 8;
	localparam int TX_IDX_W = $clog2(TX_DEPTH);
	localparam int RX_IDX_W = $clog2(RX_DEPTH);
	localparam int LEN_W = 4;
	localparam int TICK_W = 16;
	localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd20;
	localparam int PC_W = 5;
	localparam int PROG_LEN = 27;

	typedef enum logic [2:0] {
		OP_LOAD, OP_START, OP_TX_READY, OP_RX_BYTE,
		OP_NACK, OP_ARB_LOST, OP_TICK, OP_POLL
	} op_t;

	typedef enum logic [2:0] {
		ST_OK, ST_PARAM, ST_BUSY, ST_NACK, ST_TIMEOUT
	} status_t;

	typedef enum logic [2:0] {
		CMD_NONE, CMD_START_WRITE, CMD_SEND, CMD_RESTART_READ, CMD_STOP
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE, PH_TX, PH_RX, PH_DONE, PH_ERROR
	} phase_t;

	// datapath actions
	typedef enum logic [3:0] {
		A_NONE, A_TX_WR, A_JOB_START, A_RELOAD, A_END_OK, A_TX_ADV, A_TO_RX,
		A_RX_WR, A_END_NACK, A_END_TIMEOUT, A_TICK_DEC, A_POLL_INIT, A_POLL_NEXT
	} act_t;

	// jump conditions
	typedef enum logic [3:0] {
		C_NEVER, C_ALWAYS, C_PARAM_BAD, C_BUSY_ERR, C_TX_IDLE, C_RX_IDLE,
		C_NOT_BUSY, C_TICKS_NZ, C_RX_LAST, C_TX_MORE, C_RX_PENDING,
		C_POLL_BLOCK, C_POLL_SINGLE, C_POLL_MORE
	} cond_t;

	typedef enum logic [1:0] {
		SS_OK, SS_PARAM, SS_BUSY, SS_JOB
	} st_sel_t;

	typedef struct packed {
		op_t op;
		logic [6:0] target_addr;
		logic [7:0] data_byte;
		logic [2:0] byte_index;
		logic [3:0] tx_length;
		logic [3:0] rx_length;
		logic stop_pending;
	} i2cs_in_t;

	typedef struct packed {
		status_t status;
		cmd_t bus_command;
		logic [6:0] slave_address;
		logic [7:0] tx_byte;
		logic [7:0] rx_byte;
		logic [3:0] rx_total;
		logic busy_flag;
		logic done_flag;
		logic last;
	} i2cs_out_t;

	typedef struct packed {
		logic param_bad;
		logic busy_err;
		logic tx_idle;
		logic rx_idle;
		logic not_busy;
		logic ticks_nz;
		logic rx_last;
		logic tx_more;
		logic rx_pending;
		logic poll_block;
		logic poll_single;
		logic poll_more;
	} i2cs_flags_t;

	typedef struct packed {
		act_t act;
		cond_t cond;
		logic [PC_W-1:0] target;
		logic emit;
		cmd_t cmd;
		st_sel_t st_sel;
		logic addr_sel;
		logic txb_sel;
		logic rxb_sel;
		logic tot_sel;
		logic last_sel;
		logic fin;
	} uword_t;

	// result field selects: {addr, txb, rxb, tot, last}
	localparam logic [4:0] SEL_NONE = 5'b00000;
	localparam logic [4:0] SEL_ADDR = 5'b10000;
	localparam logic [4:0] SEL_TXB = 5'b01000;
	localparam logic [4:0] SEL_RXB = 5'b00100;
	localparam logic [4:0] SEL_TOT = 5'b00010;
	localparam logic [4:0] SEL_LAST = 5'b00001;

	// microprogram entry and jump addresses
	localparam logic [PC_W-1:0] PA_LOAD = 5'd0;
	localparam logic [PC_W-1:0] PA_START = 5'd1;
	localparam logic [PC_W-1:0] PA_PARAM = 5'd5;
	localparam logic [PC_W-1:0] PA_BUSY = 5'd6;
	localparam logic [PC_W-1:0] PA_TX = 5'd7;
	localparam logic [PC_W-1:0] PA_END_OK = 5'd10;
	localparam logic [PC_W-1:0] PA_TX_SEND = 5'd11;
	localparam logic [PC_W-1:0] PA_TX_RESTART = 5'd12;
	localparam logic [PC_W-1:0] PA_RX = 5'd13;
	localparam logic [PC_W-1:0] PA_EMIT = 5'd15;
	localparam logic [PC_W-1:0] PA_NACK = 5'd16;
	localparam logic [PC_W-1:0] PA_TICK = 5'd18;
	localparam logic [PC_W-1:0] PA_TICK_DEC = 5'd21;
	localparam logic [PC_W-1:0] PA_STOP = 5'd22;
	localparam logic [PC_W-1:0] PA_POLL = 5'd23;
	localparam logic [PC_W-1:0] PA_POLL_LOOP = 5'd25;
	localparam logic [PC_W-1:0] PA_POLL_ONE = 5'd26;

	function automatic uword_t mk(act_t a, cond_t c, logic [PC_W-1:0] t, logic e,
			cmd_t cm, st_sel_t s, logic [4:0] sel, logic f);
		uword_t w;
		w.act = a;
		w.cond = c;
		w.target = t;
		w.emit = e;
		w.cmd = cm;
		w.st_sel = s;
		w.addr_sel = sel[4];
		w.txb_sel = sel[3];
		w.rxb_sel = sel[2];
		w.tot_sel = sel[1];
		w.last_sel = sel[0];
		w.fin = f;
		return w;
	endfunction

	function automatic logic [PC_W-1:0] i2cs_entry(op_t op);
		logic [PC_W-1:0] a;
		case (op)
			OP_LOAD: a = PA_LOAD;
			OP_START: a = PA_START;
			OP_TX_READY: a = PA_TX;
			OP_RX_BYTE: a = PA_RX;
			OP_NACK: a = PA_NACK;
			OP_ARB_LOST: a = PA_NACK;
			OP_TICK: a = PA_TICK;
			OP_POLL: a = PA_POLL;
			default: a = PA_EMIT;
		endcase
		return a;
	endfunction

	function automatic uword_t i2cs_rom(logic [PC_W-1:0] pc);
		uword_t w;
		case (pc)
			PA_LOAD: w = mk(A_TX_WR, C_NEVER, '0, 1'b1, CMD_NONE, SS_OK, SEL_NONE, 1'b1);
			PA_START: w = mk(A_NONE, C_PARAM_BAD, PA_PARAM, 1'b0, CMD_NONE, SS_OK,
				SEL_NONE, 1'b0);
			PA_START + 5'd1: w = mk(A_NONE, C_BUSY_ERR, PA_BUSY, 1'b0, CMD_NONE, SS_OK,
				SEL_NONE, 1'b0);
			PA_START + 5'd2: w = mk(A_JOB_START, C_NEVER, '0, 1'b0, CMD_NONE, SS_OK,
				SEL_NONE, 1'b0);
			PA_START + 5'd3: w = mk(A_NONE, C_NEVER, '0, 1'b1, CMD_START_WRITE, SS_OK,
				SEL_ADDR, 1'b1);
			PA_PARAM: w = mk(A_NONE, C_NEVER, '0, 1'b1, CMD_NONE, SS_PARAM, SEL_NONE, 1'b1);
			PA_BUSY: w = mk(A_NONE, C_NEVER, '0, 1'b1, CMD_NONE, SS_BUSY, SEL_NONE, 1'b1);
			PA_TX: w = mk(A_NONE, C_TX_IDLE, PA_EMIT, 1'b0, CMD_NONE, SS_JOB, SEL_NONE, 1'b0);
			PA_TX + 5'd1: w = mk(A_RELOAD, C_TX_MORE, PA_TX_SEND, 1'b0, CMD_NONE, SS_JOB,
				SEL_NONE, 1'b0);
			PA_TX + 5'd2: w = mk(A_NONE, C_RX_PENDING, PA_TX_RESTART, 1'b0, CMD_NONE, SS_JOB,
				SEL_NONE, 1'b0);
			PA_END_OK: w = mk(A_END_OK, C_ALWAYS, PA_STOP, 1'b0, CMD_NONE, SS_JOB,
				SEL_NONE, 1'b0);
			PA_TX_SEND: w = mk(A_TX_ADV, C_NEVER, '0, 1'b1, CMD_SEND, SS_JOB, SEL_TXB, 1'b1);
			PA_TX_RESTART: w = mk(A_TO_RX, C_NEVER, '0, 1'b1, CMD_RESTART_READ, SS_JOB,
				SEL_NONE, 1'b1);
			PA_RX: w = mk(A_NONE, C_RX_IDLE, PA_EMIT, 1'b0, CMD_NONE, SS_JOB, SEL_NONE, 1'b0);
			PA_RX + 5'd1: w = mk(A_RX_WR, C_RX_LAST, PA_END_OK, 1'b0, CMD_NONE, SS_JOB,
				SEL_NONE, 1'b0);
			PA_EMIT: w = mk(A_NONE, C_NEVER, '0, 1'b1, CMD_NONE, SS_JOB, SEL_NONE, 1'b1);
			PA_NACK: w = mk(A_NONE, C_NOT_BUSY, PA_EMIT, 1'b0, CMD_NONE, SS_JOB,
				SEL_NONE, 1'b0);
			PA_NACK + 5'd1: w = mk(A_END_NACK, C_ALWAYS, PA_STOP, 1'b0, CMD_NONE, SS_JOB,
				SEL_NONE, 1'b0);
			PA_TICK: w = mk(A_NONE, C_NOT_BUSY, PA_EMIT, 1'b0, CMD_NONE, SS_JOB,
				SEL_NONE, 1'b0);
			PA_TICK + 5'd1: w = mk(A_NONE, C_TICKS_NZ, PA_TICK_DEC, 1'b0, CMD_NONE, SS_JOB,
				SEL_NONE, 1'b0);
			PA_TICK + 5'd2: w = mk(A_END_TIMEOUT, C_ALWAYS, PA_STOP, 1'b0, CMD_NONE, SS_JOB,
				SEL_NONE, 1'b0);
			PA_TICK_DEC: w = mk(A_TICK_DEC, C_NEVER, '0, 1'b1, CMD_NONE, SS_JOB,
				SEL_NONE, 1'b1);
			PA_STOP: w = mk(A_NONE, C_NEVER, '0, 1'b1, CMD_STOP, SS_JOB, SEL_NONE, 1'b1);
			PA_POLL: w = mk(A_NONE, C_POLL_BLOCK, PA_BUSY, 1'b0, CMD_NONE, SS_JOB,
				SEL_NONE, 1'b0);
			PA_POLL + 5'd1: w = mk(A_POLL_INIT, C_POLL_SINGLE, PA_POLL_ONE, 1'b0, CMD_NONE,
				SS_JOB, SEL_NONE, 1'b0);
			PA_POLL_LOOP: w = mk(A_POLL_NEXT, C_POLL_MORE, PA_POLL_LOOP, 1'b1, CMD_NONE,
				SS_JOB, SEL_RXB | SEL_TOT | SEL_LAST, 1'b1);
			PA_POLL_ONE: w = mk(A_NONE, C_NEVER, '0, 1'b1, CMD_NONE, SS_JOB, SEL_TOT, 1'b1);
			default: w = mk(A_NONE, C_NEVER, '0, 1'b0, CMD_NONE, SS_JOB, SEL_NONE, 1'b1);
		endcase
		return w;
	endfunction

endpackage

/* hdl/i2cs_seq.sv */
// ----------------------------------------------------------------------------
// i2cs_seq
// Microcode step counter: fetches the control word, resolves conditional
// jumps and holds on a result step until the output slot is free.
// ----------------------------------------------------------------------------
`include "i2c_master_transaction_sequencer_defines.svh"

module i2cs_seq (
	input logic clk,
	input logic arst_n,
	input logic start,
	input i2cs_pkg::op_t op,
	input i2cs_pkg::i2cs_flags_t flags,
	input logic slot_free,
	output i2cs_pkg::uword_t uw,
	output logic fire,
	output logic running
);
	import i2cs_pkg::*;

	logic run_q;
	logic [PC_W-1:0] pc_q;
	logic taken;

	assign uw = i2cs_rom(pc_q);
	assign fire = run_q && (!uw.emit || slot_free);
	assign running = run_q;

	always_comb begin
		case (uw.cond)
			C_NEVER: taken = 1'b0;
			C_ALWAYS: taken = 1'b1;
			C_PARAM_BAD: taken = flags.param_bad;
			C_BUSY_ERR: taken = flags.busy_err;
			C_TX_IDLE: taken = flags.tx_idle;
			C_RX_IDLE: taken = flags.rx_idle;
			C_NOT_BUSY: taken = flags.not_busy;
			C_TICKS_NZ: taken = flags.ticks_nz;
			C_RX_LAST: taken = flags.rx_last;
			C_TX_MORE: taken = flags.tx_more;
			C_RX_PENDING: taken = flags.rx_pending;
			C_POLL_BLOCK: taken = flags.poll_block;
			C_POLL_SINGLE: taken = flags.poll_single;
			C_POLL_MORE: taken = flags.poll_more;
			default: taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			pc_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			pc_q <= i2cs_entry(op);
		end else if (fire) begin
			if (taken) begin
				pc_q <= uw.target;
			end else if (uw.fin) begin
				run_q <= 1'b0;
			end else begin
				pc_q <= pc_q + 5'd1;
			end
		end
	end

	`I2CS_ASSERT_NOW(a_no_fire_idle, !run_q, !fire, "step executed while sequencer idle")
	`I2CS_ASSERT_NOW(a_pc_range, run_q, pc_q < PC_W'(PROG_LEN), "step counter left program")
	`I2CS_ASSERT_NOW(a_start_idle, start, !run_q, "transaction accepted while running")

endmodule

/* hdl/i2cs_dp.sv */
// ----------------------------------------------------------------------------
// i2cs_dp
// Job state, byte stores and result register, driven by the control word.
// ----------------------------------------------------------------------------
`include "i2c_master_transaction_sequencer_defines.svh"

module i2cs_dp (
	input logic clk,
	input logic arst_n,
	input logic in_accept,
	input i2cs_pkg::i2cs_in_t in_data,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	input i2cs_pkg::uword_t uw,
	input logic fire,
	output i2cs_pkg::i2cs_flags_t flags,
	output logic slot_free,
	output logic out_valid,
	input logic out_ready,
	output i2cs_pkg::i2cs_out_t out_data
);
	import i2cs_pkg::*;

	i2cs_in_t in_q;
	logic [TICK_W-1:0] reload_q;
	phase_t phase_q;
	logic busy_q;
	logic done_q;
	status_t status_q;
	logic [LEN_W-1:0] tx_pos_q;
	logic [LEN_W-1:0] rx_pos_q;
	logic [LEN_W-1:0] tx_len_q;
	logic [LEN_W-1:0] rx_len_q;
	logic [TICK_W-1:0] ticks_q;
	logic [RX_IDX_W-1:0] idx_q;
	logic [7:0] tx_store [TX_DEPTH];
	logic [7:0] rx_store [RX_DEPTH];
	logic out_valid_q;
	i2cs_out_t out_q;
	i2cs_out_t res;
	act_t act;
	logic poll_last;
	logic rx_room;

	assign act = fire ? uw.act : A_NONE;
	assign rx_room = rx_pos_q < rx_len_q;
	assign poll_last = (LEN_W'(idx_q) + LEN_W'(1)) == rx_len_q;

	always_comb begin
		flags.param_bad = (in_q.tx_length == '0) ||
			(in_q.tx_length > LEN_W'(TX_DEPTH)) || (in_q.rx_length > LEN_W'(RX_DEPTH));
		flags.busy_err = busy_q || in_q.stop_pending;
		flags.tx_idle = !(busy_q && (phase_q == PH_TX));
		flags.rx_idle = !(busy_q && (phase_q == PH_RX));
		flags.not_busy = !busy_q;
		flags.ticks_nz = ticks_q != '0;
		flags.rx_last = rx_room && ((rx_pos_q + LEN_W'(1)) == rx_len_q);
		flags.tx_more = tx_pos_q < tx_len_q;
		flags.rx_pending = rx_len_q != '0;
		flags.poll_block = busy_q || !done_q;
		flags.poll_single = (status_q != ST_OK) || (rx_len_q == '0);
		flags.poll_more = !poll_last;
	end

	// result fields; flags reflect state already updated by earlier steps
	always_comb begin
		case (uw.st_sel)
			SS_OK: res.status = ST_OK;
			SS_PARAM: res.status = ST_PARAM;
			SS_BUSY: res.status = ST_BUSY;
			SS_JOB: res.status = status_q;
			default: res.status = status_q;
		endcase
		res.bus_command = uw.cmd;
		res.slave_address = uw.addr_sel ? in_q.target_addr : 7'd0;
		res.tx_byte = uw.txb_sel ? tx_store[tx_pos_q[TX_IDX_W-1:0]] : 8'd0;
		res.rx_byte = uw.rxb_sel ? rx_store[idx_q] : 8'd0;
		res.rx_total = uw.tot_sel ? rx_len_q : 4'd0;
		res.busy_flag = busy_q;
		res.done_flag = done_q;
		res.last = uw.last_sel ? poll_last : 1'b1;
	end

	// payload storage, no reset
	always_ff @(posedge clk) begin
		if (in_accept) begin
			in_q <= in_data;
		end
		if (act == A_TX_WR) begin
			tx_store[in_q.byte_index] <= in_q.data_byte;
		end
		if (act == A_RX_WR && rx_room) begin
			rx_store[rx_pos_q[RX_IDX_W-1:0]] <= in_q.data_byte;
		end
		if (fire && uw.emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= TIMEOUT_RESET;
			phase_q <= PH_IDLE;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			status_q <= ST_OK;
			tx_pos_q <= '0;
			rx_pos_q <= '0;
			tx_len_q <= '0;
			rx_len_q <= '0;
			ticks_q <= '0;
			idx_q <= '0;
		end else begin
			if (cfg_we) begin
				reload_q <= cfg_wdata;
			end
			case (act)
				A_JOB_START: begin
					tx_len_q <= in_q.tx_length;
					rx_len_q <= in_q.rx_length;
					tx_pos_q <= '0;
					rx_pos_q <= '0;
					status_q <= ST_OK;
					done_q <= 1'b0;
					busy_q <= 1'b1;
					ticks_q <= reload_q;
					phase_q <= PH_TX;
				end
				A_RELOAD: ticks_q <= reload_q;
				A_TX_ADV: tx_pos_q <= tx_pos_q + LEN_W'(1);
				A_TO_RX: phase_q <= PH_RX;
				A_RX_WR: begin
					ticks_q <= reload_q;
					if (rx_room) begin
						rx_pos_q <= rx_pos_q + LEN_W'(1);
					end
				end
				A_END_OK: begin
					status_q <= ST_OK;
					busy_q <= 1'b0;
					done_q <= 1'b1;
					phase_q <= PH_DONE;
				end
				A_END_NACK: begin
					ticks_q <= reload_q;
					status_q <= ST_NACK;
					busy_q <= 1'b0;
					done_q <= 1'b1;
					phase_q <= PH_ERROR;
				end
				A_END_TIMEOUT: begin
					status_q <= ST_TIMEOUT;
					busy_q <= 1'b0;
					done_q <= 1'b1;
					phase_q <= PH_ERROR;
				end
				A_TICK_DEC: ticks_q <= ticks_q - TICK_W'(1);
				A_POLL_INIT: begin
					done_q <= 1'b0;
					idx_q <= '0;
				end
				A_POLL_NEXT: idx_q <= idx_q + RX_IDX_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && uw.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`I2CS_ASSERT_NOW(a_busy_not_done, busy_q, !done_q, "job busy and done together")
	`I2CS_ASSERT_NOW(a_busy_phase, busy_q, (phase_q == PH_TX) || (phase_q == PH_RX),
		"busy job outside transfer phase")
	`I2CS_ASSERT_NEXT(a_emit_lands, fire && uw.emit, out_valid_q, "result step lost")

endmodule

/* hdl/i2c_master_transaction_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Steps run one per cycle while the output slot is free: 1 to 5 per transaction,
// a poll up to 10 (2 plus one per received byte, 3 for a single result, or 2
// when it is refused as busy). Each result registers when its emitting step
// executes; the next transaction is accepted the cycle after the last step.
// Reset clears all control state, timeout reload returns to 20 ticks.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input i2cs_pkg::i2cs_in_t in_data,
	output logic out_valid,
	input logic out_ready,
	output i2cs_pkg::i2cs_out_t out_data,
	input logic cfg_we,
	input logic [15:0] cfg_wdata
);
	import i2cs_pkg::*;

	i2cs_flags_t flags;
	uword_t uw;
	logic fire;
	logic running;
	logic slot_free;
	logic in_accept;

	assign in_ready = !running;
	assign in_accept = in_valid && in_ready;

	i2cs_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(in_accept),
		.op(in_data.op),
		.flags(flags),
		.slot_free(slot_free),
		.uw(uw),
		.fire(fire),
		.running(running)
	);

	i2cs_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_accept(in_accept),
		.in_data(in_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.uw(uw),
		.fire(fire),
		.flags(flags),
		.slot_free(slot_free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
